FILE: rtl/bsd_pkg.sv
// Shared types and constants for the Bayer superpixel downscaler.
// Used by bsd_lane, bsd_merge and bayer_superpixel_downscaler; no dependencies.
package bsd_pkg;

   localparam int RAW_BITS       = 16;
   localparam int SCALE_BITS     = 25;
   localparam int CODE_BITS      = 8;
   localparam int NUM_SLOTS      = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CFA_PHASE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_LEVELS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SLOT0  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SLOT1  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SLOT2  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SLOT3  = 3'd5;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 25'd16777216;

   typedef struct packed {
      logic [RAW_BITS-1:0] raw_top_left;
      logic [RAW_BITS-1:0] raw_top_right;
      logic [RAW_BITS-1:0] raw_bottom_left;
      logic [RAW_BITS-1:0] raw_bottom_right;
      logic                last_tile;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] red;
      logic [CODE_BITS-1:0] green;
      logic [CODE_BITS-1:0] blue;
   } rsp_type;

   // accumulate-stage control shared by all lanes
   typedef struct packed {
      logic advance;
      logic valid;
      logic add;
      logic close;
   } lane_ctrl_type;

endpackage

FILE: rtl/bsd_lane.sv
// One slot lane: black-level subtract, scale multiply and run accumulator.
// Depends on bsd_pkg.
module bsd_lane #(
   parameter int SAMPLE_BITS     = 16,
   parameter int SCALE_FRAC_BITS = 24,
   parameter int SUM_W           = 42
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bsd_pkg::lane_ctrl_type           ctrl,
   input  logic [bsd_pkg::RAW_BITS-1:0]     raw,
   input  logic [bsd_pkg::RAW_BITS-1:0]     black,
   input  logic [bsd_pkg::SCALE_BITS-1:0]   scale,
   output logic [SUM_W-1:0]                 total
);

   localparam int SC_W   = SCALE_FRAC_BITS + 1;
   localparam int PROD_W = SAMPLE_BITS + SC_W;
   localparam int CMP_W  = (SC_W > bsd_pkg::SCALE_BITS) ? SC_W : bsd_pkg::SCALE_BITS;
   localparam logic [SC_W-1:0] ONE = SC_W'(1) << SCALE_FRAC_BITS;

   logic [SAMPLE_BITS-1:0]       raw_s;
   logic [bsd_pkg::RAW_BITS-1:0] raw_ext;
   logic [SAMPLE_BITS-1:0]       diff;
   logic [SC_W-1:0]              scale_c;
   logic [PROD_W-1:0]            prod_in;
   logic [PROD_W-1:0]            prod_ff;
   logic [SUM_W-1:0]             acc;
   logic [SUM_W-1:0]             sum_in;
   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             total_ff;

   always_comb begin
      raw_s   = raw[SAMPLE_BITS-1:0];
      raw_ext = bsd_pkg::RAW_BITS'(raw_s);
      if (raw_ext > black) begin
         diff = SAMPLE_BITS'(raw_ext - black);
      end else begin
         diff = '0;
      end
      if (CMP_W'(scale) > CMP_W'(ONE)) begin
         scale_c = ONE;
      end else begin
         scale_c = SC_W'(scale);
      end
      prod_in = PROD_W'(diff) * PROD_W'(scale_c);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      acc    = sum_ff + (ctrl.add ? SUM_W'(prod_ff) : '0);
      sum_in = sum_ff;
      if (ctrl.advance && ctrl.valid) begin
         sum_in = ctrl.close ? '0 : acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && ctrl.valid && ctrl.close) begin
         total_ff <= acc;
      end
   end

   assign total = total_ff;

endmodule

FILE: rtl/bsd_merge.sv
// Merge stage: picks slots by CFA phase, divides by run length, rounds to 8 bits.
// Holds the output register. Depends on bsd_pkg.
module bsd_merge #(
   parameter int SCALE_FRAC_BITS = 24,
   parameter int SUM_W           = 42,
   parameter int CNT_W           = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [CNT_W-1:0]      in_count,
   input  logic [1:0]            cfa_phase,
   input  logic [SUM_W-1:0]      totals [bsd_pkg::NUM_SLOTS],
   output logic                  out_valid,
   output bsd_pkg::rsp_type      out_data
);

   localparam int DW  = SCALE_FRAC_BITS + CNT_W;
   localparam int NW  = DW + 10;
   localparam int GW  = SUM_W + 1;
   localparam int GNW = NW + 1;
   localparam int XW  = 9 + CNT_W;
   localparam int QW  = XW + 10;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   logic [1:0]       idx_r;
   logic [1:0]       idx_b;
   logic [1:0]       idx_g0;
   logic [1:0]       idx_g1;
   logic [DW-1:0]    den;
   logic [SUM_W-1:0] s_r;
   logic [SUM_W-1:0] s_b;
   logic [GW-1:0]    s_g;
   logic [NW-1:0]    num_r;
   logic [NW-1:0]    num_b;
   logic [GNW-1:0]   num_g;
   logic [XW-1:0]    x_in  [3];
   logic             sat_in [3];

   logic [XW-1:0]    x_ff   [3];
   logic             sat_ff [3];
   logic [CNT_W-1:0] cnt_ff;
   logic             m1_valid_ff;
   logic             out_valid_ff;
   bsd_pkg::rsp_type out_data_ff;
   logic [bsd_pkg::CODE_BITS-1:0] code [3];

   always_comb begin
      idx_r  = cfa_phase;
      idx_b  = ~cfa_phase;
      idx_g0 = cfa_phase ^ 2'b01;
      idx_g1 = cfa_phase ^ 2'b10;
      den    = DW'(in_count) << SCALE_FRAC_BITS;
      s_r    = totals[idx_r];
      s_b    = totals[idx_b];
      s_g    = GW'(totals[idx_g0]) + GW'(totals[idx_g1]);
      num_r  = NW'(s_r[DW-1:0]) * NW'(510) + NW'(den);
      num_b  = NW'(s_b[DW-1:0]) * NW'(510) + NW'(den);
      num_g  = GNW'(s_g[DW:0]) * GNW'(510) + GNW'({den, 1'b0});
      sat_in[CH_RED]   = s_r >= SUM_W'(den);
      sat_in[CH_BLUE]  = s_b >= SUM_W'(den);
      sat_in[CH_GREEN] = s_g >= GW'({den, 1'b0});
      x_in[CH_RED]     = XW'(num_r >> (SCALE_FRAC_BITS + 1));
      x_in[CH_BLUE]    = XW'(num_b >> (SCALE_FRAC_BITS + 1));
      x_in[CH_GREEN]   = XW'(num_g >> (SCALE_FRAC_BITS + 2));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         sat_ff <= sat_in;
         cnt_ff <= in_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff  <= in_valid;
         out_valid_ff <= m1_valid_ff;
      end
   end

   // run length is 1..4: shifts, and reciprocal 683/2048 for three
   function automatic logic [XW-1:0] div_count(input logic [XW-1:0] x,
                                                input logic [2:0] cnt);
      logic [QW-1:0] prod;
      logic [XW-1:0] q;
      prod = QW'(x) * QW'(683);
      unique case (cnt)
         3'd2:    q = x >> 1;
         3'd3:    q = XW'(prod >> 11);
         3'd4:    q = x >> 2;
         default: q = x;
      endcase
      return q;
   endfunction

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (sat_ff[c]) begin
            code[c] = '1;
         end else begin
            code[c] = bsd_pkg::CODE_BITS'(div_count(x_ff[c], 3'(cnt_ff)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff.red   <= code[CH_RED];
         out_data_ff.green <= code[CH_GREEN];
         out_data_ff.blue  <= code[CH_BLUE];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: rtl/bayer_superpixel_downscaler.sv
// Top level of the Bayer superpixel downscaler: config registers, run counter,
// four slot lanes and the merge stage. Depends on bsd_pkg, bsd_lane, bsd_merge.
//
// Usage:
//   req_* carries one 2x2 raw tile per beat; last_tile closes the current run
//   of tiles and yields one RGB beat on rsp_*. Tiles past MAX_TILES in a run
//   add nothing, but their last_tile mark still closes the run.
//   csr_* writes one register per beat (0 cfa_phase, 1 black_levels,
//   2..5 scale_slot0..3); csr_ready is always high. Write only while idle.
// Timing:
//   One tile per clock while no stall is in force. The pixel for a run appears on
//   rsp_valid once its last tile has passed the product register, accumulator
//   stage, merge numerator stage, then the output register.
// Reset:
//   Synchronous; zeroes sums, count, valids, phase, black; scale=SCALE_RESET.
// Stall:
//   The pipeline moves as one; while rsp_valid is high and rsp_ready low, no
//   stage advances and req_ready is low. The held result stays stable.
module bayer_superpixel_downscaler #(
   parameter int SAMPLE_BITS     = 16,
   parameter int SCALE_FRAC_BITS = 24,
   parameter int MAX_TILES       = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bsd_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bsd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bsd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int CNT_W = $clog2(MAX_TILES + 1);
   localparam int SUM_W = SAMPLE_BITS + SCALE_FRAC_BITS + $clog2(MAX_TILES);

   logic [1:0]                      phase_ff;
   logic [bsd_pkg::CSR_DATA_BITS-1:0] black_ff;
   logic [bsd_pkg::SCALE_BITS-1:0]  scale_ff [bsd_pkg::NUM_SLOTS];

   logic                    advance;
   logic                    s1_valid_ff;
   logic                    s1_last_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;
   logic [CNT_W-1:0]        cnt_next;
   logic                    s2_valid_ff;
   logic [CNT_W-1:0]        s2_cnt_ff;
   bsd_pkg::lane_ctrl_type  lane_ctrl;
   logic [bsd_pkg::RAW_BITS-1:0] raw [bsd_pkg::NUM_SLOTS];
   logic [SUM_W-1:0]        totals [bsd_pkg::NUM_SLOTS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         black_ff <= '0;
         for (int i = 0; i < bsd_pkg::NUM_SLOTS; i++) begin
            scale_ff[i] <= bsd_pkg::SCALE_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsd_pkg::CSR_CFA_PHASE:    phase_ff    <= csr_data[1:0];
            bsd_pkg::CSR_BLACK_LEVELS: black_ff    <= csr_data;
            bsd_pkg::CSR_SCALE_SLOT0:  scale_ff[0] <= csr_data[bsd_pkg::SCALE_BITS-1:0];
            bsd_pkg::CSR_SCALE_SLOT1:  scale_ff[1] <= csr_data[bsd_pkg::SCALE_BITS-1:0];
            bsd_pkg::CSR_SCALE_SLOT2:  scale_ff[2] <= csr_data[bsd_pkg::SCALE_BITS-1:0];
            bsd_pkg::CSR_SCALE_SLOT3:  scale_ff[3] <= csr_data[bsd_pkg::SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff <= req_data.last_tile;
      end
   end

   always_comb begin
      lane_ctrl.advance = advance;
      lane_ctrl.valid   = s1_valid_ff;
      lane_ctrl.add     = cnt_ff < CNT_W'(MAX_TILES);
      lane_ctrl.close   = s1_last_ff;
      cnt_next = cnt_ff + CNT_W'(lane_ctrl.add);
      cnt_in   = cnt_ff;
      if (advance && s1_valid_ff) begin
         cnt_in = s1_last_ff ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff && s1_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_last_ff) begin
         s2_cnt_ff <= cnt_next;
      end
   end

   assign raw[0] = req_data.raw_top_left;
   assign raw[1] = req_data.raw_top_right;
   assign raw[2] = req_data.raw_bottom_left;
   assign raw[3] = req_data.raw_bottom_right;

   for (genvar g = 0; g < bsd_pkg::NUM_SLOTS; g++) begin : g_lane
      bsd_lane #(
         .SAMPLE_BITS     (SAMPLE_BITS),
         .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
         .SUM_W           (SUM_W)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .raw   (raw[g]),
         .black (black_ff[g*bsd_pkg::RAW_BITS +: bsd_pkg::RAW_BITS]),
         .scale (scale_ff[g]),
         .total (totals[g])
      );
   end

   bsd_merge #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .SUM_W           (SUM_W),
      .CNT_W           (CNT_W)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_count  (s2_cnt_ff),
      .cfa_phase (phase_ff),
      .totals    (totals),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_TILES))
      else $error("run count above limit");

   a_last_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_tile) |=> (s1_valid_ff && s1_last_ff))
      else $error("accepted last tile lost at product stage");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_last_ff) |=> (cnt_ff == '0 && s2_valid_ff))
      else $error("run close did not clear count");

   a_close_count: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_cnt_ff != '0))
      else $error("closed run with zero tiles");
`endif

endmodule
